/* rtl/zpc_pkg.sv */
// ----------------------------------------------------------------------------
// zpc_pkg
// shared constants, types and helpers of the zero padded 2d convolution
// ----------------------------------------------------------------------------
package zpc_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_FILTER = 5;
    localparam int COEF_COUNT = MAX_FILTER * MAX_FILTER;
    localparam int LINES      = MAX_FILTER - 1;
    localparam int DIM_W      = 7;
    localparam int FS_W       = 3;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int POS_W      = 13;
    localparam int CIDX_W     = 5;
    localparam int PROD_W     = 25;
    localparam int ROWSUM_W   = 28;
    localparam int VALUE_W    = 29;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FILTER = 2'd2,
        REG_SPARE  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [FS_W-1:0]  s;
        logic [1:0]       half;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic              load;
        logic [CIDX_W-1:0] cidx;
        logic [15:0]       cval;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    typedef logic [MAX_FILTER-1:0][MAX_FILTER-1:0][7:0] win_t;

    function automatic logic [CIDX_W-1:0] coef_idx(input int fr, input int fc,
                                                   input logic [FS_W-1:0] s);
        logic [CIDX_W-1:0] r;
        r = CIDX_W'(fr) * CIDX_W'(s) + CIDX_W'(fc);
        return r;
    endfunction

endpackage

/* rtl/zpc_cfg.sv */
// ----------------------------------------------------------------------------
// zpc_cfg
// register port for frame size and kernel size, values clamped for use
// ----------------------------------------------------------------------------
module zpc_cfg
    import zpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;
    logic [FS_W-1:0]  s_reg;
    reg_index_t       idx;
    logic             wr;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= DIM_W'(64);
            h_reg <= DIM_W'(64);
            s_reg <= FS_W'(3);
        end
        else if (wr)
        begin
            unique case (idx)
                REG_WIDTH:  w_reg <= pwdata[DIM_W-1:0];
                REG_HEIGHT: h_reg <= pwdata[DIM_W-1:0];
                REG_FILTER: s_reg <= pwdata[FS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WIDTH:  prdata = 32'(w_reg);
            REG_HEIGHT: prdata = 32'(h_reg);
            REG_FILTER: prdata = 32'(s_reg);
            default:    prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.w = (w_reg == '0) ? DIM_W'(1) :
                (w_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_reg;
        cfg.h = (h_reg == '0) ? DIM_W'(1) :
                (h_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_reg;
        cfg.s = (s_reg == '0) ? FS_W'(1) :
                (s_reg > FS_W'(MAX_FILTER)) ? FS_W'(MAX_FILTER) : s_reg;
        cfg.half = cfg.s[2:1];
    end

endmodule

/* rtl/zpc_line.sv */
// ----------------------------------------------------------------------------
// zpc_line
// column memory of the last rows, read-modify-write per pixel, window shift
// ----------------------------------------------------------------------------
module zpc_line
    import zpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             push,
    input  logic [COL_W-1:0] col,
    input  logic [7:0]       pix,
    output win_t             win
);

    logic [LINES*8-1:0]      mem [MAX_WIDTH];
    logic [LINES*8-1:0]      rdata_reg;
    logic [LINES*8-1:0]      wdata_reg;
    logic                    push1_reg;
    logic                    fwd1_reg;
    logic [COL_W-1:0]        col1_reg;
    logic [7:0]              pix1_reg;
    logic [LINES*8-1:0]      col_old;
    logic [MAX_FILTER*8-1:0] vec_next;
    win_t                    win_reg;

    assign col_old  = fwd1_reg ? wdata_reg : rdata_reg;
    assign vec_next = {col_old, pix1_reg};
    assign win      = win_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rdata_reg <= mem[col];
            col1_reg  <= col;
            pix1_reg  <= pix;
            if (push1_reg)
            begin
                mem[col1_reg] <= vec_next[LINES*8-1:0];
                wdata_reg     <= vec_next[LINES*8-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push1_reg <= 1'b0;
            fwd1_reg  <= 1'b0;
            win_reg   <= '0;
        end
        else if (adv)
        begin
            push1_reg <= push;
            fwd1_reg  <= push && push1_reg && (col1_reg == col);
            if (push1_reg)
            begin
                win_reg[0] <= vec_next;
                for (int j = 1; j < MAX_FILTER; j++)
                begin
                    win_reg[j] <= win_reg[j-1];
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fwd1_reg |-> push1_reg)
        else $error("forward flag without a pending write");

endmodule

/* rtl/zpc_mac.sv */
// ----------------------------------------------------------------------------
// zpc_mac
// coefficient table, tap masking, products and a registered adder tree
// ----------------------------------------------------------------------------
module zpc_mac
    import zpc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  cfg_t                      cfg,
    input  item_t                     item,
    input  win_t                      win,
    output logic                      res_valid,
    output meta_t                     res_meta,
    output logic signed [VALUE_W-1:0] res_value
);

    logic signed [15:0]         coef_reg [COEF_COUNT];
    logic signed [PROD_W-1:0]   prod_reg [MAX_FILTER][MAX_FILTER];
    logic signed [PROD_W-1:0]   prod_next [MAX_FILTER][MAX_FILTER];
    logic signed [ROWSUM_W-1:0] rsum_reg [MAX_FILTER];
    logic signed [ROWSUM_W-1:0] rsum_next [MAX_FILTER];
    logic                       v3_reg;
    logic                       v4_reg;
    meta_t                      m3_reg;
    meta_t                      m4_reg;
    logic signed [VALUE_W-1:0]  total;

    always_comb
    begin
        logic [7:0] rr;
        logic [7:0] cc;
        logic       en;
        logic [2:0] j;
        logic [2:0] k;
        for (int fr = 0; fr < MAX_FILTER; fr++)
        begin
            for (int fc = 0; fc < MAX_FILTER; fc++)
            begin
                rr = 8'(item.row) + 8'(fr);
                cc = 8'(item.col) + 8'(fc);
                en = (3'(fr) < cfg.s) && (3'(fc) < cfg.s)
                     && (rr >= 8'(cfg.half)) && (rr - 8'(cfg.half) < 8'(cfg.h))
                     && (cc >= 8'(cfg.half)) && (cc - 8'(cfg.half) < 8'(cfg.w));
                j = en ? 3'({cfg.half, 1'b0}) - 3'(fc) : 3'd0;
                k = en ? 3'({cfg.half, 1'b0}) - 3'(fr) : 3'd0;
                prod_next[fr][fc] = '0;
                if (en)
                begin
                    prod_next[fr][fc] = $signed({1'b0, win[j][k]})
                                        * coef_reg[coef_idx(fr, fc, cfg.s)];
                end
            end
        end
    end

    always_comb
    begin
        for (int fr = 0; fr < MAX_FILTER; fr++)
        begin
            rsum_next[fr] = '0;
            for (int fc = 0; fc < MAX_FILTER; fc++)
            begin
                rsum_next[fr] = rsum_next[fr] + ROWSUM_W'(prod_reg[fr][fc]);
            end
        end
        total = '0;
        for (int fr = 0; fr < MAX_FILTER; fr++)
        begin
            total = total + VALUE_W'(rsum_reg[fr]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            rsum_reg <= rsum_next;
            m3_reg   <= '{row: item.row, col: item.col, last: item.last};
            m4_reg   <= m3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            v3_reg <= item.emit;
            v4_reg <= v3_reg;
            if (item.load && (item.cidx < CIDX_W'(COEF_COUNT)))
            begin
                coef_reg[item.cidx] <= $signed(item.cval);
            end
        end
    end

    assign res_valid = v4_reg;
    assign res_meta  = m4_reg;
    assign res_value = total;

endmodule

/* rtl/zero_padded_2d_convolution.sv */
// results pass s1_reg, s2_reg, prod_reg, rsum_reg and out_valid_reg in order
// throughput: one request per cycle while the output register is not stalled
// the column memory does read-modify-write per accepted pixel with forwarding
// reset clears counters, coefficients, window and pipeline flags
// the column memory is not cleared; unwritten rows are masked by frame bounds
// ----------------------------------------------------------------------------
// zero_padded_2d_convolution
// same-size square kernel convolution over raster pixels with zero padding
// ----------------------------------------------------------------------------
module zero_padded_2d_convolution
    import zpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // coef_index, coef_value, pixel
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_value, out_row, out_col
    output logic        m_axis_tlast   // last_of_frame
);

    cfg_t                      cfg;
    logic                      adv;
    logic                      accept;
    action_t                   action;
    logic                      pix_acc;
    logic [POS_W-1:0]          q_reg;
    logic [COL_W-1:0]          qc_reg;
    logic [ROW_W-1:0]          or_reg;
    logic [COL_W-1:0]          oc_reg;
    logic [POS_W-1:0]          delay;
    logic [POS_W-1:0]          total;
    logic                      wrap;
    logic [POS_W-1:0]          q_eff;
    logic [COL_W-1:0]          qc_eff;
    logic [ROW_W-1:0]          or_eff;
    logic [COL_W-1:0]          oc_eff;
    logic                      emit;
    logic                      last;
    item_t                     s0_item;
    item_t                     s1_reg;
    item_t                     s2_reg;
    win_t                      win;
    logic                      res_valid;
    meta_t                     res_meta;
    logic signed [VALUE_W-1:0] res_value;
    logic                      out_valid_reg;
    logic [47:0]               out_data_reg;
    logic                      out_last_reg;

    zpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign action        = action_t'(s_axis_tuser);
    assign pix_acc       = accept && (action == ACT_PIXEL || action == ACT_FLUSH);

    assign delay  = POS_W'(cfg.half) * POS_W'(cfg.w) + POS_W'(cfg.half);
    assign total  = POS_W'(cfg.w) * POS_W'(cfg.h);
    assign wrap   = q_reg >= total + delay;
    assign q_eff  = wrap ? '0 : q_reg;
    assign qc_eff = wrap ? '0 : qc_reg;
    assign or_eff = wrap ? '0 : or_reg;
    assign oc_eff = wrap ? '0 : oc_reg;
    assign emit   = q_eff >= delay;
    assign last   = emit && (q_eff == total - POS_W'(1) + delay);

    always_comb
    begin
        s0_item.emit = pix_acc && emit;
        s0_item.load = accept && (action == ACT_LOAD);
        s0_item.cidx = s_axis_tdata[4:0];
        s0_item.cval = s_axis_tdata[20:5];
        s0_item.row  = or_eff;
        s0_item.col  = oc_eff;
        s0_item.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= '0;
            qc_reg <= '0;
            or_reg <= '0;
            oc_reg <= '0;
        end
        else if (pix_acc)
        begin
            if (last)
            begin
                q_reg  <= '0;
                qc_reg <= '0;
                or_reg <= '0;
                oc_reg <= '0;
            end
            else
            begin
                q_reg  <= q_eff + POS_W'(1);
                qc_reg <= (DIM_W'(qc_eff) == cfg.w - DIM_W'(1)) ? '0 : qc_eff + COL_W'(1);
                if (emit)
                begin
                    if (DIM_W'(oc_eff) == cfg.w - DIM_W'(1))
                    begin
                        oc_reg <= '0;
                        or_reg <= or_eff + ROW_W'(1);
                    end
                    else
                    begin
                        oc_reg <= oc_eff + COL_W'(1);
                        or_reg <= or_eff;
                    end
                end
                else
                begin
                    oc_reg <= oc_eff;
                    or_reg <= or_eff;
                end
            end
        end
    end

    zpc_line u_line (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .push  (pix_acc),
        .col   (qc_eff),
        .pix   ((action == ACT_PIXEL) ? s_axis_tdata[28:21] : 8'd0),
        .win   (win)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= s0_item;
            s2_reg <= s1_reg;
        end
    end

    zpc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .item      (s2_reg),
        .win       (win),
        .res_valid (res_valid),
        .res_meta  (res_meta),
        .res_value (res_value)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {7'd0, res_meta.col, res_meta.row, res_value};
            out_last_reg <= res_meta.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_valid_reg && out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_reg) && $stable(s2_reg))
        else $error("pipeline moved during a stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && last) |=> (q_reg == '0) && (or_reg == '0) && (oc_reg == '0))
        else $error("counters not cleared after end of frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        s0_item.emit |-> (q_eff >= delay) && !s0_item.load)
        else $error("output scheduled before window is complete");

endmodule
